// File: rtl/tfpc_pkg.sv
`timescale 1ns / 1ps

package tfpc_pkg;

  localparam int unsigned REG_IDX_W = 2;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PWM_PERIOD = 2'd0,
    REG_HOLD_TICKS = 2'd1,
    REG_SAMPLE_DIV = 2'd2,
    REG_START_DUTY = 2'd3
  } reg_idx_t;

  localparam logic [15:0] PWM_PERIOD_RST = 16'd65535;
  localparam logic [7:0]  HOLD_TICKS_RST = 8'd8;
  localparam logic [7:0]  SAMPLE_DIV_RST = 8'd16;
  localparam logic [7:0]  START_DUTY_RST = 8'd50;

  localparam logic [7:0]  DUTY_FULL      = 8'd200;
  localparam logic [6:0]  SETPOINT_MAX   = 7'd100;
  localparam logic [6:0]  SETPOINT_RESET = 7'd25;

  // temperature = sample * 2442 / 100000 degrees
  localparam logic [23:0] TEMP_NUM = 24'd2442;
  localparam logic [23:0] TEMP_DEN = 24'd100000;

  // x / 25 == (x * RECIP_25) >> RECIP_SHIFT, exact for x < 2^21
  localparam logic [25:0] RECIP_25    = 26'd42949673;
  localparam int unsigned RECIP_SHIFT = 30;

  typedef struct packed {
    logic        up_press_event;
    logic        down_press_event;
    logic        up_held;
    logic        down_held;
    logic [11:0] adc_sample;
  } tick_t;

  typedef struct packed {
    logic        fan_on;
    logic [7:0]  duty_half_pct;
    logic [6:0]  setpoint_deg;
    logic [11:0] latched_reading;
    logic        setpoint_stepped;
  } ctrl_result_t;

endpackage

// File: rtl/tfpc_if.sv
`timescale 1ns / 1ps

interface tfpc_tick_if;
  logic        valid;
  logic        ready;
  logic        up_press_event;
  logic        down_press_event;
  logic        up_held;
  logic        down_held;
  logic [11:0] adc_sample;

  modport source (output valid, up_press_event, down_press_event, up_held, down_held,
                  adc_sample, input ready);
  modport sink (input valid, up_press_event, down_press_event, up_held, down_held,
                adc_sample, output ready);
endinterface

interface tfpc_result_if;
  logic        valid;
  logic        ready;
  logic        fan_on;
  logic [15:0] pwm_compare;
  logic [7:0]  duty_half_pct;
  logic [6:0]  setpoint_deg;
  logic [11:0] latched_reading;
  logic        setpoint_stepped;

  modport source (output valid, fan_on, pwm_compare, duty_half_pct, setpoint_deg,
                  latched_reading, setpoint_stepped, input ready);
  modport sink (input valid, fan_on, pwm_compare, duty_half_pct, setpoint_deg,
                latched_reading, setpoint_stepped, output ready);
endinterface

interface tfpc_cfg_if import tfpc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/thermostat_fan_pwm_controller.sv
`timescale 1ns / 1ps
// Thermostat fan PWM controller.
// tick_in: one word per tick carrying the up/down press events, held levels
//   and a raw 12-bit temperature sample. result_out: one word per tick with
//   fan state, PWM compare value, duty, set point, latched sample and a
//   set point change flag.
// cfg: register writes (pwm_period, hold_ticks, sample_div, start_duty),
//   always ready; write only while no tick is in flight.
// Pipeline: four registered stages (input register,
//   control state update, period*duty product, divide-by-200 by reciprocal).
// Throughput: one tick per cycle unless result_out stalls; control state
//   updates once per tick, so back-to-back ticks see each other's results.
// Each of the four stages holds its word when the stage after it is full and
//   stalled; empty stages keep filling, so tick_in stays ready until all four
//   are occupied behind a stalled result_out.
// Reset: registers return to 65535 / 8 / 16 / 50, set point 25, fan off,
//   duty 50, all counters and the latched sample cleared, pipeline emptied.
module thermostat_fan_pwm_controller import tfpc_pkg::*; (
  input logic           clk,
  input logic           rst,
  tfpc_tick_if.sink     tick_in,
  tfpc_result_if.source result_out,
  tfpc_cfg_if.sink      cfg
);

  logic [15:0] pwm_period;
  logic [7:0]  hold_ticks;
  logic [7:0]  sample_div;
  logic [7:0]  start_duty;

  logic         s0_valid, s1_valid, s2_valid, o_valid;
  tick_t        s0_tick;
  ctrl_result_t ctrl_res, s1_res, s2_res, o_res;
  logic [23:0]  s2_prod;
  logic [15:0]  o_compare;

  logic        o_free, s2_free, s1_free, s0_free, step;
  logic [46:0] recip_prod;
  logic [15:0] quotient;

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PWM_PERIOD_RST;
      hold_ticks <= HOLD_TICKS_RST;
      sample_div <= SAMPLE_DIV_RST;
      start_duty <= START_DUTY_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_PWM_PERIOD: pwm_period <= cfg.data;
        REG_HOLD_TICKS: hold_ticks <= cfg.data[7:0];
        REG_SAMPLE_DIV: sample_div <= cfg.data[7:0];
        REG_START_DUTY: start_duty <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign o_free   = !o_valid || result_out.ready;
  assign s2_free  = !s2_valid || o_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s0_free  = !s0_valid || s1_free;
  assign step     = s0_valid && s1_free;
  assign tick_in.ready = s0_free;

  tfpc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .tick       (s0_tick),
    .hold_ticks (hold_ticks),
    .sample_div (sample_div),
    .start_duty (start_duty),
    .res        (ctrl_res)
  );

  // p / 200 = (p >> 3) / 25
  assign recip_prod = 47'(s2_prod[23:3]) * 47'(RECIP_25);
  assign quotient   = recip_prod[RECIP_SHIFT +: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      o_valid  <= 1'b0;
    end else begin
      if (s0_free) s0_valid <= tick_in.valid;
      if (s1_free) s1_valid <= s0_valid;
      if (s2_free) s2_valid <= s1_valid;
      if (o_free)  o_valid  <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_free && tick_in.valid) begin
      s0_tick.up_press_event   <= tick_in.up_press_event;
      s0_tick.down_press_event <= tick_in.down_press_event;
      s0_tick.up_held          <= tick_in.up_held;
      s0_tick.down_held        <= tick_in.down_held;
      s0_tick.adc_sample       <= tick_in.adc_sample;
    end
    if (step) begin
      s1_res <= ctrl_res;
    end
    if (s2_free && s1_valid) begin
      s2_res  <= s1_res;
      s2_prod <= 24'(pwm_period) * 24'(s1_res.duty_half_pct);
    end
    if (o_free && s2_valid) begin
      o_res     <= s2_res;
      o_compare <= s2_res.fan_on ? quotient : '0;
    end
  end

  assign result_out.valid            = o_valid;
  assign result_out.fan_on           = o_res.fan_on;
  assign result_out.pwm_compare      = o_compare;
  assign result_out.duty_half_pct    = o_res.duty_half_pct;
  assign result_out.setpoint_deg     = o_res.setpoint_deg;
  assign result_out.latched_reading  = o_res.latched_reading;
  assign result_out.setpoint_stepped = o_res.setpoint_stepped;

  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.duty_half_pct <= DUTY_FULL)
    else $error("duty above full scale");

  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.setpoint_deg <= SETPOINT_MAX)
    else $error("set point above limit");

  a_fan_off_compare: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.fan_on |-> result_out.pwm_compare == '0)
    else $error("nonzero compare with fan off");

  a_stall_holds_ctrl: assert property (@(posedge clk) disable iff (rst)
    s0_valid && !s1_free |=> s0_valid && $stable(s0_tick))
    else $error("input word lost while control stage blocked");

endmodule

// File: rtl/tfpc_ctrl.sv
`timescale 1ns / 1ps

module tfpc_ctrl import tfpc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  tick_t        tick,
  input  logic [7:0]   hold_ticks,
  input  logic [7:0]   sample_div,
  input  logic [7:0]   start_duty,
  output ctrl_result_t res
);

  logic [7:0]  sample_count, sample_count_next;
  logic [11:0] held_sample, held_sample_next;
  logic [7:0]  up_hold_count, up_hold_count_next;
  logic [7:0]  down_hold_count, down_hold_count_next;
  logic        up_armed, up_armed_next;
  logic        down_armed, down_armed_next;
  logic [6:0]  target_deg, target_deg_next;
  logic        running, running_next;
  logic [7:0]  duty_now, duty_now_next;

  logic [8:0]  count_inc;
  logic [23:0] temp_scaled;
  logic [23:0] target_scaled;
  logic [7:0]  start_val;

  assign start_val = (start_duty > DUTY_FULL) ? DUTY_FULL : start_duty;

  always_comb begin
    up_armed_next   = up_armed | tick.up_press_event;
    down_armed_next = down_armed | tick.down_press_event;

    // divider compares with one extra bit so 255 still wraps
    count_inc = {1'b0, sample_count} + 9'd1;
    if (count_inc > {1'b0, sample_div}) begin
      sample_count_next = '0;
      held_sample_next  = tick.adc_sample;
    end else begin
      sample_count_next = count_inc[7:0];
      held_sample_next  = held_sample;
    end

    up_hold_count_next   = up_hold_count;
    down_hold_count_next = down_hold_count;
    if (up_hold_count < hold_ticks && tick.up_held) begin
      up_hold_count_next = up_hold_count + 8'd1;
    end else if (down_hold_count < hold_ticks && tick.down_held) begin
      down_hold_count_next = down_hold_count + 8'd1;
    end

    if (!tick.up_held) begin
      up_hold_count_next = '0;
      up_armed_next      = 1'b0;
    end
    if (!tick.down_held) begin
      down_hold_count_next = '0;
      down_armed_next      = 1'b0;
    end

    target_deg_next = target_deg;
    if (up_hold_count_next >= hold_ticks || down_hold_count_next >= hold_ticks) begin
      if (down_armed_next) begin
        if (target_deg != '0) target_deg_next = target_deg - 7'd1;
      end else if (up_armed_next) begin
        if (target_deg < SETPOINT_MAX) target_deg_next = target_deg + 7'd1;
      end
      up_hold_count_next   = '0;
      down_hold_count_next = '0;
    end

    temp_scaled   = 24'(held_sample_next) * TEMP_NUM;
    target_scaled = 24'(target_deg_next) * TEMP_DEN;

    running_next  = running;
    duty_now_next = duty_now;
    if (temp_scaled > target_scaled) begin
      // first hot tick only switches on; ramp starts on the next one
      if (!running) begin
        running_next = 1'b1;
      end else if (duty_now < DUTY_FULL) begin
        duty_now_next = duty_now + 8'd1;
      end
    end else begin
      running_next  = 1'b0;
      duty_now_next = start_val;
    end

    res.fan_on           = running_next;
    res.duty_half_pct    = duty_now_next;
    res.setpoint_deg     = target_deg_next;
    res.latched_reading  = held_sample_next;
    res.setpoint_stepped = (target_deg_next != target_deg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      held_sample     <= '0;
      up_hold_count   <= '0;
      down_hold_count <= '0;
      up_armed        <= 1'b0;
      down_armed      <= 1'b0;
      target_deg      <= SETPOINT_RESET;
      running         <= 1'b0;
      duty_now        <= START_DUTY_RST;
    end else if (step) begin
      sample_count    <= sample_count_next;
      held_sample     <= held_sample_next;
      up_hold_count   <= up_hold_count_next;
      down_hold_count <= down_hold_count_next;
      up_armed        <= up_armed_next;
      down_armed      <= down_armed_next;
      target_deg      <= target_deg_next;
      running         <= running_next;
      duty_now        <= duty_now_next;
    end
  end

endmodule
